### hw/rtl/i2cseq_pkg.sv
// Shared types and constants for the I2C register transaction sequencer.
package i2cseq_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_STEP  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        STP_IDLE    = 3'd0,
        STP_START   = 3'd1,
        STP_ADDR    = 3'd2,
        STP_REG     = 3'd3,
        STP_RESTART = 3'd4,
        STP_ADDR2   = 3'd5,
        STP_DATA    = 3'd6,
        STP_STOP    = 3'd7
    } t_step;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    localparam int unsigned DEV_ADDR_W = 7;
    localparam int unsigned DATA_W     = 24;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reg_index;
        logic [15:0] write_value;
        logic [1:0]  transfer_length;
        logic        bus_ack;
        logic        bus_ready;
        logic [7:0]  bus_read_byte;
    } t_in_word;

    typedef struct packed {
        logic              request_accepted;
        logic [2:0]        bus_command;
        logic [7:0]        command_byte;
        logic              read_send_ack;
        logic              busy_res;
        logic              error_flag;
        logic              data_acked;
        logic [DATA_W-1:0] result_value;
    } t_out_word;

endpackage

### hw/rtl/i2cseq_in_if.sv
// Input channel: requests and sequencer steps with the engine answer.
interface i2cseq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  reg_index;
    logic [15:0] write_value;
    logic [1:0]  transfer_length;
    logic        bus_ack;
    logic        bus_ready;
    logic [7:0]  bus_read_byte;

    modport source (
        output valid, kind, reg_index, write_value, transfer_length,
               bus_ack, bus_ready, bus_read_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, reg_index, write_value, transfer_length,
               bus_ack, bus_ready, bus_read_byte,
        output ready
    );
endinterface

### hw/rtl/i2cseq_out_if.sv
// Output channel: one result word per input word.
interface i2cseq_out_if;
    logic        valid;
    logic        ready;
    logic        request_accepted;
    logic [2:0]  bus_command;
    logic [7:0]  command_byte;
    logic        read_send_ack;
    logic        busy_res;
    logic        error_flag;
    logic        data_acked;
    logic [23:0] result_value;

    modport source (
        output valid, request_accepted, bus_command, command_byte, read_send_ack,
               busy_res, error_flag, data_acked, result_value,
        input  ready
    );
    modport sink (
        input  valid, request_accepted, bus_command, command_byte, read_send_ack,
               busy_res, error_flag, data_acked, result_value,
        output ready
    );
endinterface

### hw/rtl/i2c_register_transaction_sequencer.sv
// Top level of the I2C register transaction sequencer.
//
//   channel   dir  handshake     carries
//   i_in      in   valid/ready   kind, reg_index, write_value, transfer_length,
//                                bus_ack, bus_ready, bus_read_byte
//   o_out     out  valid/ready   one result word per input word
//   i_cfg_*   in   write enable  device_address (7 bits)
//
// One word per cycle, stalling only when both output buffer entries are full;
// each result is registered as its word is taken. The state registers update
// in the cycle the input word is taken; the next word can follow at once. A
// two-entry output buffer keeps input flowing while one result waits.
// Reset (synchronous, active low) leaves the sequencer idle with cleared state.
module i2c_register_transaction_sequencer
    import i2cseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [DEV_ADDR_W-1:0] i_cfg_wdata,
    i2cseq_in_if.sink             i_in,
    i2cseq_out_if.source          o_out
);

    t_in_word  w_in_word;
    t_out_word w_res;
    logic      w_can_take;
    logic      w_fire;

    assign i_in.ready = w_can_take;
    assign w_fire     = i_in.valid && w_can_take;

    always_comb begin
        w_in_word.kind            = i_in.kind;
        w_in_word.reg_index       = i_in.reg_index;
        w_in_word.write_value     = i_in.write_value;
        w_in_word.transfer_length = i_in.transfer_length;
        w_in_word.bus_ack         = i_in.bus_ack;
        w_in_word.bus_ready       = i_in.bus_ready;
        w_in_word.bus_read_byte   = i_in.bus_read_byte;
    end

    i2cseq_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (w_fire),
        .i_word      (w_in_word),
        .o_res       (w_res)
    );

    i2cseq_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_fire),
        .i_word     (w_res),
        .o_can_take (w_can_take),
        .o_out      (o_out)
    );

endmodule

### hw/rtl/i2cseq_core.sv
// Transaction state and the per-word next-state / command logic.
module i2cseq_core
    import i2cseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [DEV_ADDR_W-1:0] i_cfg_wdata,
    input  logic                  i_fire,
    input  t_in_word              i_word,
    output t_out_word             o_res
);

    logic [DEV_ADDR_W-1:0] r_dev_addr;
    t_step                 r_step, n_step;
    logic                  r_rd, n_rd;
    logic [1:0]            r_cnt, n_cnt;
    logic [7:0]            r_reg_num, n_reg_num;
    logic [DATA_W-1:0]     r_data, n_data;
    logic                  r_err, n_err;
    logic                  r_ack, n_ack;

    logic [7:0]        w_addr;
    logic              w_len_ok;
    logic [7:0]        w_wr_byte;
    logic [DATA_W-1:0] w_rd_shifted;
    t_cmd              w_cmd;
    logic [7:0]        w_cbyte;
    logic              w_sack;
    logic              w_accepted;

    assign w_addr = {r_dev_addr, 1'b0};

    always_comb begin
        // data byte for the current count, MSB first
        case (r_cnt)
            2'd2:    w_wr_byte = r_data[15:8];
            2'd3:    w_wr_byte = r_data[23:16];
            default: w_wr_byte = r_data[7:0];
        endcase
        case (r_cnt)
            2'd2:    w_rd_shifted = {8'h00, i_word.bus_read_byte, 8'h00};
            2'd3:    w_rd_shifted = {i_word.bus_read_byte, 16'h0000};
            default: w_rd_shifted = {16'h0000, i_word.bus_read_byte};
        endcase
    end

    always_comb begin
        n_step     = r_step;
        n_rd       = r_rd;
        n_cnt      = r_cnt;
        n_reg_num  = r_reg_num;
        n_data     = r_data;
        n_err      = r_err;
        n_ack      = r_ack;
        w_cmd      = CMD_NONE;
        w_cbyte    = 8'h00;
        w_sack     = 1'b0;
        w_accepted = 1'b0;
        w_len_ok   = 1'b0;

        case (i_word.kind)
            KIND_READ, KIND_WRITE: begin
                if (i_word.kind == KIND_READ) begin
                    w_len_ok = (i_word.transfer_length != 2'd0);
                end else begin
                    w_len_ok = i_word.transfer_length inside {2'd1, 2'd2};
                end
                if (r_step == STP_IDLE && w_len_ok) begin
                    w_accepted = 1'b1;
                    n_step     = STP_START;
                    n_rd       = (i_word.kind == KIND_READ);
                    n_cnt      = i_word.transfer_length;
                    n_reg_num  = i_word.reg_index;
                    n_err      = 1'b0;
                    n_ack      = 1'b0;
                    if (i_word.kind == KIND_READ) begin
                        n_data = '0;
                    end else if (i_word.transfer_length == 2'd1) begin
                        n_data = {16'h0000, i_word.write_value[7:0]};
                    end else begin
                        n_data = {8'h00, i_word.write_value};
                    end
                end
            end
            KIND_STEP: begin
                case (r_step)
                    STP_START: begin
                        w_cmd  = CMD_START;
                        n_step = STP_ADDR;
                    end
                    STP_RESTART: begin
                        w_cmd  = CMD_START;
                        n_step = STP_ADDR2;
                    end
                    STP_STOP: begin
                        w_cmd  = CMD_STOP;
                        n_step = STP_IDLE;
                        n_rd   = 1'b0;
                        n_cnt  = 2'd0;
                    end
                    STP_ADDR, STP_REG, STP_ADDR2: begin
                        w_cmd = CMD_WRITE;
                        if (r_step == STP_ADDR) begin
                            w_cbyte = w_addr;
                        end else if (r_step == STP_REG) begin
                            w_cbyte = r_reg_num;
                        end else begin
                            w_cbyte = w_addr | 8'h01;
                        end
                        if (i_word.bus_ready) begin
                            if (!i_word.bus_ack) begin
                                n_err  = 1'b1;
                                n_step = STP_STOP;
                            end else if (r_step == STP_REG && r_rd) begin
                                n_step = STP_RESTART;
                            end else begin
                                n_step = STP_DATA;
                            end
                        end
                    end
                    STP_DATA: begin
                        if (r_rd) begin
                            w_cmd  = CMD_READ;
                            w_sack = (r_cnt > 2'd1);
                            if (i_word.bus_ready) begin
                                n_data = r_data | w_rd_shifted;
                                if (r_cnt > 2'd1) begin
                                    n_cnt = r_cnt - 2'd1;
                                end else begin
                                    n_step = STP_STOP;
                                end
                            end
                        end else begin
                            w_cmd   = CMD_WRITE;
                            w_cbyte = w_wr_byte;
                            if (i_word.bus_ready) begin
                                if (r_cnt > 2'd1) begin
                                    if (i_word.bus_ack) begin
                                        n_cnt = r_cnt - 2'd1;
                                    end else begin
                                        n_err  = 1'b1;
                                        n_step = STP_STOP;
                                    end
                                end else begin
                                    // final byte: its ack is reported
                                    n_ack  = i_word.bus_ack;
                                    n_err  = r_err | ~i_word.bus_ack;
                                    n_step = STP_STOP;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.request_accepted = w_accepted;
        o_res.bus_command      = w_cmd;
        o_res.command_byte     = w_cbyte;
        o_res.read_send_ack    = w_sack;
        o_res.busy_res         = (n_step != STP_IDLE);
        o_res.error_flag       = n_err;
        o_res.data_acked       = n_ack;
        o_res.result_value     = n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= '0;
            r_step     <= STP_IDLE;
            r_rd       <= 1'b0;
            r_cnt      <= 2'd0;
            r_reg_num  <= 8'h00;
            r_data     <= '0;
            r_err      <= 1'b0;
            r_ack      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dev_addr <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_step    <= n_step;
                r_rd      <= n_rd;
                r_cnt     <= n_cnt;
                r_reg_num <= n_reg_num;
                r_data    <= n_data;
                r_err     <= n_err;
                r_ack     <= n_ack;
            end
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_accepted) |=> (r_step == STP_START))
        else $error("accepted request did not move to start");

    a_stop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_word.kind == KIND_STEP && r_step == STP_STOP)
        |=> (r_step == STP_IDLE))
        else $error("stop step did not return to idle");

    a_busy_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STP_IDLE) |-> (r_cnt != 2'd0))
        else $error("transaction in progress with zero byte count");

    a_write_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STP_IDLE && !r_rd) |-> (r_cnt != 2'd3))
        else $error("write transaction holds three bytes");

endmodule

### hw/rtl/i2cseq_obuf.sv
// Two-entry output register with skid stage for the result channel.
module i2cseq_obuf
    import i2cseq_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_out_word      i_word,
    output logic           o_can_take,
    i2cseq_out_if.source   o_out
);

    logic      r_out_valid;
    logic      r_skid_valid;
    t_out_word r_out;
    t_out_word r_skid;
    logic      w_pop;

    assign w_pop      = r_out_valid && o_out.ready;
    assign o_can_take = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            // a push only comes while the skid stage is empty
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= i_word;
            end else begin
                r_skid <= i_word;
            end
        end else if (w_pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.request_accepted = r_out.request_accepted;
    assign o_out.bus_command      = r_out.bus_command;
    assign o_out.command_byte     = r_out.command_byte;
    assign o_out.read_send_ack    = r_out.read_send_ack;
    assign o_out.busy_res         = r_out.busy_res;
    assign o_out.error_flag       = r_out.error_flag;
    assign o_out.data_acked       = r_out.data_acked;
    assign o_out.result_value     = r_out.result_value;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_out.ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid word not moved to output register");

    a_push_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !r_out_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("word pushed into empty buffer not shown");

endmodule
